[src/htpa_pkg.sv]
`default_nettype none

package htpa_pkg;

	// Operation codes carried in the kind field.
	typedef enum logic [1:0] {
		KIND_CREATE   = 2'd0,
		KIND_REMOVE   = 2'd1,
		KIND_CONTAINS = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SLOT,
		S_COMMIT
	} state_t;

	localparam int HANDLE_W = 16;
	localparam int COUNT_W  = 9;
	localparam int DENSE_W  = 8;

	// Slot derived from an incoming handle.
	typedef struct packed {
		logic [HANDLE_W-1:0] slot;
		logic                in_range;
		logic                exact;
	} slot_info_t;

endpackage

`default_nettype wire

[src/htpa_req_if.sv]
`default_nettype none

interface htpa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] handle_in;

	modport source (output valid, output kind, output handle_in, input ready);
	modport sink (input valid, input kind, input handle_in, output ready);
endinterface

`default_nettype wire

[src/htpa_rsp_if.sv]
`default_nettype none

interface htpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] handle_out;
	logic [7:0]  dense_index;
	logic        present;
	logic [1:0]  status;
	logic [8:0]  live_total;

	modport source (output valid, output handle_out, output dense_index, output present,
		output status, output live_total, input ready);
	modport sink (input valid, input handle_out, input dense_index, input present,
		input status, input live_total, output ready);
endinterface

`default_nettype wire

[src/htpa_slot_calc.sv]
`default_nettype none

// Reduces a 16-bit handle modulo MAX_SLOTS by a reciprocal multiply.
// The quotient is registered at the input transfer; the remainder is then
// formed combinationally from it and the held handle.
module htpa_slot_calc import htpa_pkg::*; #(
	parameter int MAX_SLOTS = 256,
	parameter int DEPTH     = 256
) (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire logic [HANDLE_W-1:0] handle_new,
	input  wire logic [HANDLE_W-1:0] handle_held,
	output      slot_info_t          info
);

	localparam int SHIFT = HANDLE_W + $clog2(MAX_SLOTS);
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(MAX_SLOTS) - 64'd1) / 64'(MAX_SLOTS);

	logic [48:0]         prod;
	logic [HANDLE_W-1:0] quot_q;
	logic [32:0]         qd;
	logic [32:0]         rem;

	// Quotient estimate, exact for every 16-bit handle with this shift.
	assign prod = 49'(handle_new) * 49'(RECIP[16:0]);

	always_ff @(posedge clk) begin
		if (load) begin
			quot_q <= prod[SHIFT +: HANDLE_W];
		end
	end

	// Remainder and range checks.
	assign qd  = 33'(quot_q) * 33'(MAX_SLOTS);
	assign rem = 33'(handle_held) - qd;

	always_comb begin
		info.slot     = rem[HANDLE_W-1:0];
		info.in_range = rem < 33'(DEPTH);
		info.exact    = handle_held == rem[HANDLE_W-1:0];
	end

endmodule

`default_nettype wire

[src/htpa_slot_mem.sv]
`default_nettype none

// Slot-indexed tables: free-list link and dense position of each slot.
// One shared registered read, separate writes for each field.
module htpa_slot_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output      logic [AW-1:0] rd_next,
	output      logic [AW-1:0] rd_dense,
	input  wire logic          next_we,
	input  wire logic [AW-1:0] next_addr,
	input  wire logic [AW-1:0] next_wdata,
	input  wire logic          dense_we,
	input  wire logic [AW-1:0] dense_addr,
	input  wire logic [AW-1:0] dense_wdata
);

	logic [AW-1:0] next_mem [DEPTH];
	logic [AW-1:0] dense_mem [DEPTH];

	// Write ports.
	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_addr] <= next_wdata;
		end
		if (dense_we) begin
			dense_mem[dense_addr] <= dense_wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_next  <= next_mem[rd_addr];
			rd_dense <= dense_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/htpa_dense_mem.sv]
`default_nettype none

// Dense position to slot map, one write and one registered read port.
module htpa_dense_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output      logic [AW-1:0] rd_data,
	input  wire logic          we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] wr_data
);

	logic [AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/handle_table_packed_array_top.sv]
// A result is registered at commit, after the transfer and the slot stage.
// A new request is taken only after the previous one commits, since ready
// is high only in idle; each passes through transfer, slot reduction and
// table read, and commit. A stalled result holds the commit stage.
// Reset: arst_n empties the table at once and loads a slot count of 256;
// memories hold no reset state and need no clearing pass.
`default_nettype none

module handle_table_packed_array_top import htpa_pkg::*; #(
	parameter int MAX_SLOTS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	htpa_req_if.sink        req,
	htpa_rsp_if.source      rsp,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_wdata
);

	localparam int DEPTH = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
	localparam int AW    = $clog2(DEPTH);

	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   slots_q;
	logic [COUNT_W-1:0]   active_q;
	logic [COUNT_W-1:0]   active_new;
	logic [AW-1:0]        head_q, tail_q;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic [DEPTH-1:0]     live_q;
	logic                 fresh_q;
	kind_t                kind_q;
	logic [HANDLE_W-1:0]  hin_q;
	logic [AW-1:0]        slot_s1;
	logic                 live_s1;
	logic                 exact_s1;
	slot_info_t           info;
	logic [AW-1:0]        slot_cur;
	logic                 accept;
	logic                 commit;

	logic                 rsp_valid_q;
	logic [HANDLE_W-1:0]  rsp_handle_q;
	logic [DENSE_W-1:0]   rsp_dense_q;
	logic                 rsp_present_q;
	status_t              rsp_status_q;
	logic [COUNT_W-1:0]   rsp_total_q;

	logic                 sm_rd_en;
	logic [AW-1:0]        sm_rd_addr, sm_rd_next, sm_rd_dense;
	logic                 sm_next_we, sm_dense_we;
	logic [AW-1:0]        sm_next_addr, sm_next_wdata, sm_dense_addr, sm_dense_wdata;
	logic [AW-1:0]        dm_rd_data, dm_wr_addr, dm_wr_data;
	logic                 dm_we;

	logic                 full;
	logic                 create_ok;
	logic                 remove_ok;
	logic                 head_last;
	logic [AW-1:0]        link_dflt;
	logic [AW-1:0]        link_eff;
	logic [HANDLE_W-1:0]  res_handle;
	logic [DENSE_W-1:0]   res_dense;
	logic                 res_present;
	status_t              res_status;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign commit   = (state_q == S_COMMIT) && (!rsp_valid_q || rsp.ready);
	assign slot_cur = info.slot[AW-1:0];

	// Handle to slot reduction.
	htpa_slot_calc #(
		.MAX_SLOTS (MAX_SLOTS),
		.DEPTH     (DEPTH)
	) u_calc (
		.clk         (clk),
		.load        (accept),
		.handle_new  (req.handle_in),
		.handle_held (hin_q),
		.info        (info)
	);

	// Table memories, read in the slot stage.
	assign sm_rd_en   = (state_q == S_SLOT);
	assign sm_rd_addr = (kind_q == KIND_CREATE) ? head_q : slot_cur;

	htpa_slot_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_slot_mem (
		.clk         (clk),
		.rd_en       (sm_rd_en),
		.rd_addr     (sm_rd_addr),
		.rd_next     (sm_rd_next),
		.rd_dense    (sm_rd_dense),
		.next_we     (sm_next_we),
		.next_addr   (sm_next_addr),
		.next_wdata  (sm_next_wdata),
		.dense_we    (sm_dense_we),
		.dense_addr  (sm_dense_addr),
		.dense_wdata (sm_dense_wdata)
	);

	htpa_dense_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_dense_mem (
		.clk     (clk),
		.rd_en   (sm_rd_en),
		.rd_addr (AW'(count_q - 9'd1)),
		.rd_data (dm_rd_data),
		.we      (dm_we),
		.wr_addr (dm_wr_addr),
		.wr_data (dm_wr_data)
	);

	// Slot count clamped to the range the tables can hold.
	always_comb begin
		if (slots_q < 9'd2) begin
			active_new = 9'd2;
		end else if (slots_q > 9'(DEPTH)) begin
			active_new = 9'(DEPTH);
		end else begin
			active_new = slots_q;
		end
	end

	// Free-list link of the head slot. While the head still walks the initial
	// chain of never allocated slots, the link is simply the next slot number.
	// The last slot of that chain and every slot returned by a remove have a
	// stored link by the time a create can take them.
	always_comb begin
		head_last = (9'(head_q) + 9'd1) >= active_q;
		link_dflt = AW'(9'(head_q) + 9'd1);
		link_eff  = (fresh_q && !head_last) ? link_dflt : sm_rd_next;
	end

	assign full      = (10'(count_q) + 10'd1) >= 10'(active_q);
	assign create_ok = (kind_q == KIND_CREATE) && !full;
	assign remove_ok = (kind_q == KIND_REMOVE) && live_s1 && (count_q != '0);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SLOT;
				end
			end
			S_SLOT: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commit stage: table writes and the result fields.
	always_comb begin
		sm_next_we     = 1'b0;
		sm_next_addr   = tail_q;
		sm_next_wdata  = slot_s1;
		sm_dense_we    = 1'b0;
		sm_dense_addr  = head_q;
		sm_dense_wdata = count_q[AW-1:0];
		dm_we          = 1'b0;
		dm_wr_addr     = count_q[AW-1:0];
		dm_wr_data     = head_q;
		res_handle     = '0;
		res_dense      = '0;
		res_present    = 1'b0;
		res_status     = ST_OK;
		count_d        = count_q;
		case (kind_q)
			KIND_CREATE: begin
				if (create_ok) begin
					sm_dense_we = commit;
					dm_we       = commit;
					res_handle  = HANDLE_W'(head_q);
					res_dense   = DENSE_W'(count_q[AW-1:0]);
					res_present = 1'b1;
					count_d     = count_q + 9'd1;
				end else begin
					res_status = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				res_handle = hin_q;
				if (remove_ok) begin
					sm_dense_we    = commit;
					sm_dense_addr  = dm_rd_data;
					sm_dense_wdata = sm_rd_dense;
					dm_we          = commit;
					dm_wr_addr     = sm_rd_dense;
					dm_wr_data     = dm_rd_data;
					sm_next_we     = commit;
					res_dense      = DENSE_W'(sm_rd_dense);
					count_d        = count_q - 9'd1;
				end else begin
					res_status = ST_ABSENT;
				end
			end
			KIND_CONTAINS: begin
				res_handle = hin_q;
				if (live_s1 && exact_s1) begin
					res_present = 1'b1;
					res_dense   = DENSE_W'(sm_rd_dense);
				end else begin
					res_status = ST_ABSENT;
				end
			end
			KIND_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// Sequencer, request capture and slot stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(req.kind);
			hin_q  <= req.handle_in;
		end
		if (state_q == S_SLOT) begin
			slot_s1  <= slot_cur;
			live_s1  <= info.in_range && live_q[slot_cur];
			exact_s1 <= info.exact;
		end
	end

	// Configuration register and table control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= 9'd256;
			active_q <= 9'(DEPTH);
			head_q   <= '0;
			tail_q   <= AW'(DEPTH - 1);
			count_q  <= '0;
			live_q   <= '0;
			fresh_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			if (commit) begin
				count_q <= count_d;
				if (kind_q == KIND_CLEAR) begin
					active_q <= active_new;
					head_q   <= '0;
					tail_q   <= AW'(active_new - 9'd1);
					live_q   <= '0;
					fresh_q  <= 1'b1;
				end
				if (create_ok) begin
					head_q         <= link_eff;
					live_q[head_q] <= 1'b1;
					if (head_last) begin
						fresh_q <= 1'b0;
					end
				end
				if (remove_ok) begin
					tail_q          <= slot_s1;
					live_q[slot_s1] <= 1'b0;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_handle_q  <= res_handle;
			rsp_dense_q   <= res_dense;
			rsp_present_q <= res_present;
			rsp_status_q  <= res_status;
			rsp_total_q   <= count_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.handle_out  = rsp_handle_q;
	assign rsp.dense_index = rsp_dense_q;
	assign rsp.present     = rsp_present_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.live_total  = rsp_total_q;

	// The live count always matches the number of live slots.
	a_count_matches_live: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live_q) == int'(count_q))
		else $error("live count differs from live slot bits");

	// At most one slot short of the active count is ever live.
	a_count_below_active: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < active_q)
		else $error("live count reached the active slot count");

	// The free-list head handed out by a create is never a live slot.
	a_head_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && create_ok) |-> !live_q[head_q])
		else $error("create took a slot that is already live");

endmodule

`default_nettype wire
